@@ rtl/core/lattice_equilibrium_difference_top_assert.svh @@
// Assertion macros for the equilibrium difference block.
`ifndef LATTICE_EQUILIBRIUM_DIFFERENCE_TOP_ASSERT_SVH
`define LATTICE_EQUILIBRIUM_DIFFERENCE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LED_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/led_pkg.sv @@
package led_pkg;

	localparam logic [4:0] LAST_DIR = 5'd26;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	// floor(x / 216) via floor(floor((x + 216 * Q_OFFSET) / 8) / 27) - Q_OFFSET
	localparam logic [32:0] RU_BIAS = 33'd16;
	localparam logic [31:0] RECIP_27 = 32'd2545165806;
	localparam logic [33:0] Q_OFFSET = 34'd9942054;
	// floor(t / 216) for t below 2^14
	localparam logic [14:0] RECIP_216 = 15'd19419;

	typedef enum logic [1:0] {
		CO_ZERO,
		CO_POS,
		CO_NEG
	} coord_t;

	typedef struct packed {
		coord_t cx;
		coord_t cy;
		coord_t cz;
		logic [2:0] wsh;
	} dir_t;

	typedef enum logic [2:0] {
		NS_IDLE,
		NS_MOM,
		NS_PREP,
		NS_DIV,
		NS_VEL,
		NS_SQ,
		NS_DONE
	} node_state_t;

	typedef struct packed {
		logic signed [31:0] rho;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [31:0] usq;
		logic signed [31:0] rho_b;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [31:0] usq_b;
		logic fault;
	} node_t;

	typedef struct packed {
		logic valid;
		logic [4:0] dir;
		logic fault;
		logic last;
	} ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return S32_MAX;
		end else if (v < -64'sd2147483648) begin
			return S32_MIN;
		end
		return v[31:0];
	endfunction

	function automatic dir_t dir_lookup(input logic [4:0] k);
		dir_t d;
		d = '{cx: CO_ZERO, cy: CO_ZERO, cz: CO_ZERO, wsh: 3'd0};
		if (k inside {5'd1, 5'd7, 5'd9, 5'd11, 5'd13, 5'd19, 5'd21, 5'd23, 5'd25}) begin
			d.cx = CO_POS;
		end else if (k inside {5'd2, 5'd8, 5'd10, 5'd12, 5'd14, 5'd20, 5'd22, 5'd24, 5'd26}) begin
			d.cx = CO_NEG;
		end
		if (k inside {5'd3, 5'd7, 5'd8, 5'd15, 5'd17, 5'd19, 5'd20, 5'd23, 5'd24}) begin
			d.cy = CO_POS;
		end else if (k inside {5'd4, 5'd9, 5'd10, 5'd16, 5'd18, 5'd21, 5'd22, 5'd25, 5'd26}) begin
			d.cy = CO_NEG;
		end
		if (k inside {5'd5, 5'd11, 5'd12, 5'd15, 5'd16, 5'd19, 5'd20, 5'd21, 5'd22}) begin
			d.cz = CO_POS;
		end else if (k inside {5'd6, 5'd13, 5'd14, 5'd17, 5'd18, 5'd23, 5'd24, 5'd25, 5'd26}) begin
			d.cz = CO_NEG;
		end
		// weights 64, 16, 4, 1 over 216
		if (k == 5'd0) begin
			d.wsh = 3'd6;
		end else if (k inside {[5'd1:5'd6]}) begin
			d.wsh = 3'd4;
		end else if (k inside {[5'd7:5'd18]}) begin
			d.wsh = 3'd2;
		end
		return d;
	endfunction

endpackage

@@ rtl/core/led_node.sv @@
module led_node (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] bulk_density,
	input  logic signed [31:0] bulk_vel_x,
	input  logic signed [31:0] bulk_vel_y,
	input  logic signed [31:0] bulk_vel_z,
	input  logic signed [31:0] pert_density,
	input  logic signed [31:0] pert_vel_x,
	input  logic signed [31:0] pert_vel_y,
	input  logic signed [31:0] pert_vel_z,
	output led_pkg::node_t     node,
	output logic               node_valid,
	input  logic               node_take
);
	import led_pkg::*;

	node_state_t state_q, state_d;
	logic [3:0] cnt_q;
	logic [1:0] ax;
	logic accept;

	logic signed [31:0] rb_q, rk_q, rho_q;
	logic signed [31:0] ub_q [3];
	logic signed [31:0] uk_q [3];
	logic signed [40:0] mom_q [3];
	logic [31:0] rem_q [3];
	logic [31:0] num_q [3];
	logic [31:0] quo_q [3];
	logic [31:0] dvs_q;
	logic neg_q [3];
	logic ovf_q [3];
	logic signed [31:0] vel_q [3];
	logic [63:0] acc_m_q, acc_b_q;

	logic signed [31:0] mul_a_x, mul_a_y;
	logic signed [63:0] prod_a, prod_b;
	logic fault;

	function automatic logic signed [31:0] sel3(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic signed [31:0] c, input logic [1:0] i);
		case (i)
			2'd0: return a;
			2'd1: return b;
			default: return c;
		endcase
	endfunction

	// one restoring step: {quotient bit, new remainder}
	function automatic logic [32:0] div_step(input logic [31:0] r, input logic nb,
		input logic [31:0] d);
		logic [32:0] r2;
		r2 = {r, nb};
		if (r2 >= {1'b0, d}) begin
			r2 = r2 - {1'b0, d};
			return {1'b1, r2[31:0]};
		end
		return {1'b0, r2[31:0]};
	endfunction

	function automatic logic signed [31:0] cap_usq(input logic [63:0] acc);
		if (acc[63:55] != 9'd0) begin
			return S32_MAX;
		end
		return acc[55:24];
	endfunction

	assign ax = cnt_q[1:0];
	assign accept = in_valid && !in_stall;
	assign fault = (rho_q == 32'sd0);

	always_comb begin
		case (state_q)
			NS_DIV: begin
				mul_a_x = sel3(ub_q[0], ub_q[1], ub_q[2], ax);
				mul_a_y = mul_a_x;
			end
			NS_SQ: begin
				mul_a_x = sel3(vel_q[0], vel_q[1], vel_q[2], ax);
				mul_a_y = mul_a_x;
			end
			default: begin
				mul_a_x = rb_q;
				mul_a_y = sel3(ub_q[0], ub_q[1], ub_q[2], ax);
			end
		endcase
	end

	assign prod_a = mul_a_x * mul_a_y;
	assign prod_b = rk_q * sel3(uk_q[0], uk_q[1], uk_q[2], ax);

	always_comb begin
		state_d = state_q;
		case (state_q)
			NS_IDLE: if (accept) state_d = NS_MOM;
			NS_MOM:  if (cnt_q == 4'd2) state_d = NS_PREP;
			NS_PREP: state_d = NS_DIV;
			NS_DIV:  if (cnt_q == 4'd15) state_d = NS_VEL;
			NS_VEL:  state_d = NS_SQ;
			NS_SQ:   if (cnt_q == 4'd2) state_d = NS_DONE;
			NS_DONE: if (node_take) state_d = NS_IDLE;
			default: state_d = NS_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != NS_IDLE);
		node_valid = (state_q == NS_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NS_IDLE;
			cnt_q <= 4'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				NS_MOM, NS_SQ: cnt_q <= (cnt_q == 4'd2) ? 4'd0 : cnt_q + 4'd1;
				NS_DIV: cnt_q <= cnt_q + 4'd1;
				default: cnt_q <= 4'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic [40:0] am;
		logic [31:0] ar;
		logic [32:0] st;
		case (state_q)
			NS_IDLE: begin
				if (accept) begin
					rb_q <= bulk_density;
					rk_q <= pert_density;
					ub_q[0] <= bulk_vel_x;
					ub_q[1] <= bulk_vel_y;
					ub_q[2] <= bulk_vel_z;
					uk_q[0] <= pert_vel_x;
					uk_q[1] <= pert_vel_y;
					uk_q[2] <= pert_vel_z;
					rho_q <= sat32(64'(bulk_density) + 64'(pert_density));
				end
			end
			NS_MOM: begin
				for (int a = 0; a < 3; a++) begin
					if (ax == 2'(a)) begin
						mom_q[a] <= 41'(prod_a >>> 24) + 41'(prod_b >>> 24);
					end
				end
			end
			NS_PREP: begin
				ar = rho_q[31] ? 32'(-rho_q) : 32'(rho_q);
				dvs_q <= ar;
				acc_b_q <= 64'd0;
				for (int a = 0; a < 3; a++) begin
					am = mom_q[a][40] ? 41'(-mom_q[a]) : 41'(mom_q[a]);
					ovf_q[a] <= (am >= {2'b00, ar, 7'd0});
					neg_q[a] <= mom_q[a][40] ^ rho_q[31];
					rem_q[a] <= am[39:8];
					num_q[a] <= {am[7:0], 24'd0};
				end
			end
			NS_DIV: begin
				// two quotient bits per axis
				for (int a = 0; a < 3; a++) begin
					st = div_step(rem_q[a], num_q[a][31], dvs_q);
					quo_q[a][1] <= st[32];
					st = div_step(st[31:0], num_q[a][30], dvs_q);
					quo_q[a][0] <= st[32];
					quo_q[a][31:2] <= quo_q[a][29:0];
					rem_q[a] <= st[31:0];
					num_q[a] <= {num_q[a][29:0], 2'b00};
				end
				if (cnt_q < 4'd3) begin
					acc_b_q <= acc_b_q + 64'(prod_a);
				end
			end
			NS_VEL: begin
				acc_m_q <= 64'd0;
				for (int a = 0; a < 3; a++) begin
					if (fault) begin
						vel_q[a] <= 32'sd0;
					end else if (ovf_q[a]) begin
						vel_q[a] <= neg_q[a] ? S32_MIN : S32_MAX;
					end else begin
						vel_q[a] <= neg_q[a] ? 32'(-quo_q[a]) : quo_q[a];
					end
				end
			end
			NS_SQ: begin
				acc_m_q <= acc_m_q + 64'(prod_a);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		node.rho = rho_q;
		node.vx = vel_q[0];
		node.vy = vel_q[1];
		node.vz = vel_q[2];
		node.usq = cap_usq(acc_m_q);
		node.rho_b = rb_q;
		node.bx = ub_q[0];
		node.by = ub_q[1];
		node.bz = ub_q[2];
		node.usq_b = cap_usq(acc_b_q);
		node.fault = fault;
	end

endmodule

@@ rtl/core/led_lane.sv @@
module led_lane (
	input  logic               clk,
	input  logic               adv,
	input  logic [4:0]         k,
	input  logic signed [31:0] rho,
	input  logic signed [31:0] vx,
	input  logic signed [31:0] vy,
	input  logic signed [31:0] vz,
	input  logic signed [31:0] usq,
	output logic signed [31:0] feq
);
	import led_pkg::*;

	dir_t d;
	logic signed [33:0] uc_sum;
	logic signed [63:0] sq_p, rb_p;
	logic signed [37:0] b2;
	logic [32:0] ru;
	logic [25:0] q;
	logic signed [33:0] q0, q216, r0w;
	logic [28:0] fr;

	logic signed [31:0] uc_s1, rho_s1, usq_s1;
	logic [2:0] wsh_s1;
	logic signed [31:0] uc_s2, uc2_s2, rho_s2, usq_s2;
	logic [2:0] wsh_s2;
	logic signed [31:0] b_s3, rho_s3;
	logic [2:0] wsh_s3;
	logic signed [31:0] rhob_s4;
	logic [2:0] wsh_s4;
	logic [61:0] prod_s5;
	logic signed [31:0] rhob_s5;
	logic [2:0] wsh_s5;
	logic signed [31:0] qn_s6;
	logic [13:0] t2_s6;
	logic signed [31:0] feq_s7;

	function automatic logic signed [33:0] term(input coord_t c, input logic signed [31:0] v);
		case (c)
			CO_POS: return 34'(v);
			CO_NEG: return -34'(v);
			default: return 34'sd0;
		endcase
	endfunction

	assign d = dir_lookup(k);
	assign uc_sum = term(d.cx, vx) + term(d.cy, vy) + term(d.cz, vz);
	assign sq_p = uc_s1 * uc_s1;
	assign b2 = 38'sd33554432 + 38'sd6 * 38'(uc_s2) + 38'sd9 * 38'(uc2_s2)
		- 38'sd3 * 38'(usq_s2);
	assign rb_p = rho_s3 * b_s3;
	assign ru = {1'b0, ~rhob_s4[31], rhob_s4[30:0]} + RU_BIAS;
	assign q = prod_s5[61:36];
	assign q0 = 34'({8'd0, q}) - 34'(Q_OFFSET);
	assign q216 = (q0 <<< 7) + (q0 <<< 6) + (q0 <<< 4) + (q0 <<< 3);
	assign r0w = 34'(rhob_s5) - q216;
	assign fr = 29'(t2_s6) * 29'(RECIP_216);

	always_ff @(posedge clk) begin
		if (adv) begin
			uc_s1 <= sat32(64'(uc_sum));
			rho_s1 <= rho;
			usq_s1 <= usq;
			wsh_s1 <= d.wsh;

			uc_s2 <= uc_s1;
			uc2_s2 <= sat32(sq_p >>> 24);
			rho_s2 <= rho_s1;
			usq_s2 <= usq_s1;
			wsh_s2 <= wsh_s1;

			b_s3 <= sat32(64'(b2 >>> 1));
			rho_s3 <= rho_s2;
			wsh_s3 <= wsh_s2;

			rhob_s4 <= sat32(rb_p >>> 24);
			wsh_s4 <= wsh_s3;

			prod_s5 <= 62'(ru[32:3]) * 62'(RECIP_27);
			rhob_s5 <= rhob_s4;
			wsh_s5 <= wsh_s4;

			qn_s6 <= 32'(q0) <<< wsh_s5;
			t2_s6 <= 14'(r0w[7:0]) << wsh_s5;

			feq_s7 <= qn_s6 + 32'(fr[28:22]);
		end
	end

	assign feq = feq_s7;

endmodule

@@ rtl/core/led_seq.sv @@
module led_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  led_pkg::node_t     node,
	input  logic               node_valid,
	output logic               node_take,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [4:0]         direction,
	output logic signed [31:0] eq_difference,
	output logic               last_direction,
	output logic               density_fault
);
	import led_pkg::*;

	node_t node_q;
	logic active_q;
	logic [4:0] dir_q;
	logic advance, issue;
	logic signed [31:0] feq_m, feq_b;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	logic signed [31:0] diff_s8;

	// the whole pipe holds while a finished result waits
	assign advance = !ctl_s8.valid || !res_stall;
	assign issue = advance && active_q;
	assign node_take = node_valid && (!active_q || (issue && dir_q == LAST_DIR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			dir_q <= 5'd0;
		end else if (node_take) begin
			active_q <= 1'b1;
			dir_q <= 5'd0;
		end else if (issue) begin
			active_q <= (dir_q != LAST_DIR);
			dir_q <= dir_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (node_take) begin
			node_q <= node;
		end
	end

	led_lane u_lane_mix (
		.clk (clk),
		.adv (advance),
		.k   (dir_q),
		.rho (node_q.rho),
		.vx  (node_q.vx),
		.vy  (node_q.vy),
		.vz  (node_q.vz),
		.usq (node_q.usq),
		.feq (feq_m)
	);

	led_lane u_lane_bulk (
		.clk (clk),
		.adv (advance),
		.k   (dir_q),
		.rho (node_q.rho_b),
		.vx  (node_q.bx),
		.vy  (node_q.by),
		.vz  (node_q.bz),
		.usq (node_q.usq_b),
		.feq (feq_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else if (advance) begin
			ctl_s1 <= '{valid: issue, dir: dir_q, fault: node_q.fault,
				last: (dir_q == LAST_DIR)};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			diff_s8 <= sat32(64'(feq_m) - 64'(feq_b));
		end
	end

	assign res_valid = ctl_s8.valid;
	assign direction = ctl_s8.dir;
	assign eq_difference = diff_s8;
	assign last_direction = ctl_s8.last;
	assign density_fault = ctl_s8.fault;

endmodule

@@ rtl/core/lattice_equilibrium_difference_top.sv @@
// A node enters the node unit, which works in steps (momentum, setup, velocity
// divide at two quotient bits per cycle, sign fix, speed square) and then hands the node
// to the direction sequencer; its direction results come out of the lane stages and the
// final subtract register. The sequencer issues one direction result per cycle while the
// result side does not stall, and the node unit can take the next node meanwhile.
// Reset: arst_n clears all control and valid state at once; no clearing pass is needed.
`include "lattice_equilibrium_difference_top_assert.svh"

module lattice_equilibrium_difference_top (
	input  logic               clk,
	input  logic               arst_n,
	// node channel
	input  logic               node_valid,
	output logic               node_stall,
	input  logic signed [31:0] bulk_density,
	input  logic signed [31:0] bulk_vel_x,
	input  logic signed [31:0] bulk_vel_y,
	input  logic signed [31:0] bulk_vel_z,
	input  logic signed [31:0] pert_density,
	input  logic signed [31:0] pert_vel_x,
	input  logic signed [31:0] pert_vel_y,
	input  logic signed [31:0] pert_vel_z,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic [4:0]         direction,
	output logic signed [31:0] eq_difference,
	output logic               last_direction,
	output logic               density_fault
);
	import led_pkg::*;

	node_t node;
	logic node_ready;
	logic node_take;

	// Node unit: mixture density, momentum, divided velocity and both speed
	// squares. It takes the next transaction as soon as the previous node has
	// been handed to the direction sequencer, so it works ahead of the stream.
	led_node u_node (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (node_valid),
		.in_stall     (node_stall),
		.bulk_density (bulk_density),
		.bulk_vel_x   (bulk_vel_x),
		.bulk_vel_y   (bulk_vel_y),
		.bulk_vel_z   (bulk_vel_z),
		.pert_density (pert_density),
		.pert_vel_x   (pert_vel_x),
		.pert_vel_y   (pert_vel_y),
		.pert_vel_z   (pert_vel_z),
		.node         (node),
		.node_valid   (node_ready),
		.node_take    (node_take)
	);

	// Direction sequencer: issue one direction per cycle into two equal
	// equilibrium lanes (mixture and bulk), subtract and saturate at the end.
	// A stall on the result side holds every stage; nothing drops or repeats.
	led_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.node           (node),
		.node_valid     (node_ready),
		.node_take      (node_take),
		.res_valid      (result_valid),
		.res_stall      (result_stall),
		.direction      (direction),
		.eq_difference  (eq_difference),
		.last_direction (last_direction),
		.density_fault  (density_fault)
	);

	`LED_ASSERT_NOW(a_last_dir, result_valid && last_direction, direction == LAST_DIR, "last flag off direction 26")
	`LED_ASSERT_NEXT(a_busy_after_accept, node_valid && !node_stall, node_stall, "node unit took a second transaction while busy")
	`LED_ASSERT_NEXT(a_run_order, result_valid && !result_stall && !last_direction, !result_valid || (direction == $past(direction) + 5'd1 && density_fault == $past(density_fault)), "direction run broken")

endmodule
